[rtl/assert_macros.svh]
// Assertion macros shared by the culling block's RTL files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property that must hold at every rising edge outside reset.
`define FPC_ASSERT(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Condition that must never be seen at a rising edge outside reset.
`define FPC_ASSERT_NEVER(lbl, clk, rst, cond, msg) \
  `FPC_ASSERT(lbl, clk, rst, !(cond), msg)

`endif

[rtl/fpc_pkg.sv]
// Shared types, constants and helpers of the frustum point culling block.
package fpc_pkg;

  // Matrix entries are signed Q8.8; plane coefficients are sums or differences of two entries.
  localparam int ENTRY_W     = 16;
  localparam int COEF_W      = ENTRY_W + 1;
  localparam int MAT_DIM     = 4;
  localparam int PLANE_COUNT = 6;
  localparam int QUEUE_DEPTH = 4;

  // Configuration port.
  localparam int CFG_INDEX_W = 4;
  localparam int CFG_DATA_W  = 64;

  localparam logic [CFG_INDEX_W-1:0] CFG_PROJ_COL0  = 4'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_PROJ_COL1  = 4'd1;
  localparam logic [CFG_INDEX_W-1:0] CFG_PROJ_COL2  = 4'd2;
  localparam logic [CFG_INDEX_W-1:0] CFG_PROJ_COL3  = 4'd3;
  localparam logic [CFG_INDEX_W-1:0] CFG_MODEL_COL0 = 4'd4;
  localparam logic [CFG_INDEX_W-1:0] CFG_MODEL_COL1 = 4'd5;
  localparam logic [CFG_INDEX_W-1:0] CFG_MODEL_COL2 = 4'd6;
  localparam logic [CFG_INDEX_W-1:0] CFG_MODEL_COL3 = 4'd7;

  // The fourth matrix row, from which every clip plane is formed.
  localparam logic [1:0] PLANE_BASE_ROW = 2'd3;

  typedef logic [MAT_DIM-1:0][CFG_DATA_W-1:0] mat_cols_t;

  typedef struct packed {
    logic full;
    logic empty;
  } fpc_q_status_t;

  // Entry of one packed column: row r sits in bits 16r+15..16r.
  function automatic logic signed [ENTRY_W-1:0] col_entry(logic [CFG_DATA_W-1:0] col,
                                                          logic [1:0] row);
    return $signed(col[{row, 4'b0000} +: ENTRY_W]);
  endfunction

endpackage

[rtl/fpc_if.sv]
// Stream interfaces of the culling block: vertex words in, visibility words out.
interface fpc_vertex_if #(parameter int COORD_WIDTH = 16) ();
  logic                          valid;
  logic                          ready;
  logic signed [COORD_WIDTH-1:0] vertex_x;
  logic signed [COORD_WIDTH-1:0] vertex_y;
  logic signed [COORD_WIDTH-1:0] vertex_z;
  logic signed [COORD_WIDTH-1:0] vertex_w;
  logic                          last_vertex;

  modport source (output valid, vertex_x, vertex_y, vertex_z, vertex_w, last_vertex,
                  input ready);
  modport sink   (input valid, vertex_x, vertex_y, vertex_z, vertex_w, last_vertex,
                  output ready);
endinterface

interface fpc_result_if ();
  logic valid;
  logic ready;
  logic object_visible;

  modport source (output valid, object_visible, input ready);
  modport sink   (input valid, object_visible, output ready);
endinterface

[rtl/frustum_point_cull.sv]
// Top level of the frustum point culling block.
//
// The block receives one object's vertices as a stream of words on vin, each a
// signed Q8.8 point (x, y, z, w) with last_vertex marking the final vertex. Every
// vertex is transformed by the model matrix and tested against the six clip planes
// taken from the view-projection matrix; the transformed w is not computed and is taken as one. When the
// last vertex has been tested, one word leaves on vout: object_visible is set if
// any vertex of the object lay inside all six planes, and a new object begins.
// Vertices that are not last produce no word.
//
// The user must write both matrices through the configuration port (indices 0 to 3 for the
// projection columns, 4 to 7 for the model columns) while the block is idle; the block does not check.
// A vertex word is accepted every cycle while vin.ready is high; the rate is set by the
// two-stage transform front and the two-stage plane test behind a four-word queue, all
// of which take one word a cycle. A result passes the front stages, the queue, the
// plane-test stages and the output register. When vout stalls, the plane test holds,
// the queue fills, and the front then drops vin.ready until the output register is taken.
// Reset clears the matrices, the running visibility flag and every valid bit.
module frustum_point_cull #(
  parameter int COORD_WIDTH = 16
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_we,
  input  logic [fpc_pkg::CFG_INDEX_W-1:0]   cfg_index,
  input  logic [fpc_pkg::CFG_DATA_W-1:0]    cfg_data,
  fpc_vertex_if.sink                        vin,
  fpc_result_if.source                      vout
);
  import fpc_pkg::*;

  localparam int T_WIDTH = COORD_WIDTH + ENTRY_W + 2;
  localparam int Q_WIDTH = 3 * T_WIDTH + 1;

  mat_cols_t        proj_col;
  mat_cols_t        model_col;
  fpc_q_status_t    q_status;
  logic             push;
  logic [Q_WIDTH-1:0] push_data;
  logic             pop;
  logic [Q_WIDTH-1:0] pop_data;

  // Matrix registers. Writes to indices beyond the list are ignored.
  always_ff @(posedge clk) begin
    if (rst) begin
      proj_col  <= '0;
      model_col <= '0;
    end else if (cfg_we) begin
      case (cfg_index) inside
        CFG_PROJ_COL0, CFG_PROJ_COL1, CFG_PROJ_COL2, CFG_PROJ_COL3: begin
          proj_col[cfg_index[1:0]] <= cfg_data;
        end
        CFG_MODEL_COL0, CFG_MODEL_COL1, CFG_MODEL_COL2, CFG_MODEL_COL3: begin
          model_col[cfg_index[1:0]] <= cfg_data;
        end
        default: begin
        end
      endcase
    end
  end

  // Transform front: accepts vertex words and pushes transformed points.
  fpc_front #(.COORD_WIDTH(COORD_WIDTH)) u_front (
    .clk       (clk),
    .rst       (rst),
    .vin       (vin),
    .model_col (model_col),
    .q_status  (q_status),
    .push      (push),
    .push_data (push_data)
  );

  // The queue lets the front keep accepting while the output is briefly held.
  fpc_queue #(.WIDTH(Q_WIDTH)) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_data),
    .pop       (pop),
    .pop_data  (pop_data),
    .status    (q_status)
  );

  // Plane tests, the running visibility flag and the output register.
  fpc_back #(.COORD_WIDTH(COORD_WIDTH)) u_back (
    .clk      (clk),
    .rst      (rst),
    .proj_col (proj_col),
    .q_status (q_status),
    .pop      (pop),
    .pop_data (pop_data),
    .vout     (vout)
  );

endmodule

[rtl/fpc_front.sv]
// Front end: takes vertex words and transforms them by the model matrix.
`include "assert_macros.svh"

module fpc_front #(
  parameter int COORD_WIDTH = 16,
  localparam int T_WIDTH = COORD_WIDTH + fpc_pkg::ENTRY_W + 2
) (
  input  logic                      clk,
  input  logic                      rst,
  fpc_vertex_if.sink                vin,
  input  fpc_pkg::mat_cols_t        model_col,
  input  fpc_pkg::fpc_q_status_t    q_status,
  output logic                      push,
  output logic [3*T_WIDTH:0]        push_data
);
  import fpc_pkg::*;

  localparam int PROD_W = ENTRY_W + COORD_WIDTH;

  logic                          en;
  logic signed [COORD_WIDTH-1:0] vtx [MAT_DIM];
  logic                          s1_valid;
  logic                          s1_last;
  logic signed [PROD_W-1:0]      s1_prod [3][MAT_DIM];
  logic                          s2_valid;
  logic                          s2_last;
  logic signed [T_WIDTH-1:0]     s2_t [3];

  assign vtx[0] = vin.vertex_x;
  assign vtx[1] = vin.vertex_y;
  assign vtx[2] = vin.vertex_z;
  assign vtx[3] = vin.vertex_w;

  // The whole front moves together; it only halts when its last stage cannot push.
  assign en        = !s2_valid || !q_status.full;
  assign vin.ready = en;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
    end else if (en) begin
      s1_valid <= vin.valid;
      s2_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int r = 0; r < 3; r++) begin
        for (int c = 0; c < MAT_DIM; c++) begin
          s1_prod[r][c] <= col_entry(model_col[c], 2'(r)) * vtx[c];
        end
        s2_t[r] <= T_WIDTH'(s1_prod[r][0]) + T_WIDTH'(s1_prod[r][1])
                 + T_WIDTH'(s1_prod[r][2]) + T_WIDTH'(s1_prod[r][3]);
      end
      s1_last <= vin.last_vertex;
      s2_last <= s1_last;
    end
  end

  assign push      = s2_valid && !q_status.full;
  assign push_data = {s2_last, s2_t[2], s2_t[1], s2_t[0]};

  `FPC_ASSERT(a_front_hold, clk, rst, s2_valid && q_status.full |=> s2_valid && $stable(s2_last), "front lost a word while the queue was full")
  `FPC_ASSERT(a_front_ready, clk, rst, !s2_valid |-> vin.ready, "front refused a word with an empty output stage")

endmodule

[rtl/fpc_queue.sv]
// Short register queue that decouples the transform front from the plane tests.
`include "assert_macros.svh"

module fpc_queue #(
  parameter int WIDTH = 8
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   push,
  input  logic [WIDTH-1:0]       push_data,
  input  logic                   pop,
  output logic [WIDTH-1:0]       pop_data,
  output fpc_pkg::fpc_q_status_t status
);
  import fpc_pkg::*;

  localparam int PTR_W = $clog2(QUEUE_DEPTH);

  logic [WIDTH-1:0] slot [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [PTR_W:0]   count;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot[wr_ptr] <= push_data;
    end
  end

  assign pop_data     = slot[rd_ptr];
  assign status.full  = (count == (PTR_W + 1)'(QUEUE_DEPTH));
  assign status.empty = (count == '0);

  `FPC_ASSERT_NEVER(a_q_overflow, clk, rst, push && status.full, "push into a full queue")
  `FPC_ASSERT_NEVER(a_q_underflow, clk, rst, pop && status.empty, "pop from an empty queue")

endmodule

[rtl/fpc_back.sv]
// Back end: tests transformed vertices against the six clip planes and reports.
`include "assert_macros.svh"

module fpc_back #(
  parameter int COORD_WIDTH = 16,
  localparam int T_WIDTH = COORD_WIDTH + fpc_pkg::ENTRY_W + 2
) (
  input  logic                   clk,
  input  logic                   rst,
  input  fpc_pkg::mat_cols_t     proj_col,
  input  fpc_pkg::fpc_q_status_t q_status,
  output logic                   pop,
  input  logic [3*T_WIDTH:0]     pop_data,
  fpc_result_if.source           vout
);
  import fpc_pkg::*;

  localparam int PROD_W   = COEF_W + T_WIDTH;
  localparam int ACC_FULL = PROD_W + 2;
  // Sums wrap at 64 bits for the widest coordinates, as two's complement arithmetic.
  localparam int ACC_W    = (ACC_FULL > 64) ? 64 : ACC_FULL;
  localparam int D_W      = COEF_W + 16;

  logic                     en;
  logic signed [COEF_W-1:0] coef [PLANE_COUNT][MAT_DIM];
  logic signed [T_WIDTH-1:0] t_in [3];
  logic signed [PROD_W-1:0] mul [PLANE_COUNT][3];
  logic signed [D_W-1:0]    dterm [PLANE_COUNT];
  logic                     a_valid;
  logic                     a_last;
  logic signed [ACC_W-1:0]  a_term [PLANE_COUNT][MAT_DIM];
  logic [PLANE_COUNT-1:0]   plane_neg;
  logic                     b_valid;
  logic                     b_last;
  logic                     b_inside;
  logic                     any_inside;
  logic                     out_valid;
  logic                     visible;

  // Coefficients follow proj_col; user, not block, must change it only while idle.
  always_ff @(posedge clk) begin
    for (int p = 0; p < PLANE_COUNT; p++) begin
      for (int c = 0; c < MAT_DIM; c++) begin
        if ((p & 1) != 0) begin
          coef[p][c] <= COEF_W'(col_entry(proj_col[c], PLANE_BASE_ROW))
                      - COEF_W'(col_entry(proj_col[c], 2'(p >> 1)));
        end else begin
          coef[p][c] <= COEF_W'(col_entry(proj_col[c], PLANE_BASE_ROW))
                      + COEF_W'(col_entry(proj_col[c], 2'(p >> 1)));
        end
      end
    end
  end

  for (genvar i = 0; i < 3; i++) begin : g_unpack
    assign t_in[i] = $signed(pop_data[i*T_WIDTH +: T_WIDTH]);
  end

  always_comb begin
    for (int p = 0; p < PLANE_COUNT; p++) begin
      for (int c = 0; c < 3; c++) begin
        mul[p][c] = coef[p][c] * t_in[c];
      end
      // w is taken as one, so the constant term is d scaled to Q.24.
      dterm[p] = $signed({coef[p][3], 16'b0});
    end
  end

  assign en  = !out_valid || vout.ready;
  assign pop = en && !q_status.empty;

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid    <= 1'b0;
      b_valid    <= 1'b0;
      any_inside <= 1'b0;
      out_valid  <= 1'b0;
    end else if (en) begin
      a_valid <= !q_status.empty;
      b_valid <= a_valid;
      if (b_valid && b_last) begin
        out_valid  <= 1'b1;
        any_inside <= 1'b0;
      end else begin
        out_valid <= 1'b0;
        if (b_valid) begin
          any_inside <= any_inside | b_inside;
        end
      end
    end
  end

  always_comb begin
    for (int p = 0; p < PLANE_COUNT; p++) begin
      plane_neg[p] = a_term[p][0][ACC_W-1] ^ 1'b0;
      plane_neg[p] = ACC_W'(a_term[p][0] + a_term[p][1] + a_term[p][2] + a_term[p][3])
                     < 0;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int p = 0; p < PLANE_COUNT; p++) begin
        for (int c = 0; c < 3; c++) begin
          a_term[p][c] <= ACC_W'(mul[p][c]);
        end
        a_term[p][3] <= ACC_W'(dterm[p]);
      end
      a_last   <= pop_data[3*T_WIDTH];
      b_last   <= a_last;
      b_inside <= ~|plane_neg;
      if (b_valid && b_last) begin
        visible <= any_inside | b_inside;
      end
    end
  end

  assign vout.valid          = out_valid;
  assign vout.object_visible = visible;

  `FPC_ASSERT(a_back_report, clk, rst, en && b_valid && b_last |=> vout.valid && !any_inside, "last vertex did not produce a result")
  `FPC_ASSERT(a_back_stall, clk, rst, !en |=> $stable(b_valid) && $stable(any_inside), "back end moved while the output stalled")

endmodule
